// File: rtl/dda_pkg.sv
// Package for the DDA line rasterizer: tile and fixed-point constants,
// transaction structs, the line descriptor and the coordinate clamp.
// No dependencies.
package dda_pkg;

  localparam int TILE_SIZE     = 64;
  localparam int FRACTION_BITS = 16;
  localparam int COORD_W       = 6;
  localparam int QUOT_W        = COORD_W + FRACTION_BITS;
  localparam int INC_W         = FRACTION_BITS + 2;
  localparam int ACC_W         = COORD_W + FRACTION_BITS + 1;
  localparam int DIV_CNT_W     = $clog2(QUOT_W);
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [INC_W-1:0]   xinc;
    logic [INC_W-1:0]   yinc;
    logic [COORD_W-1:0] len;
  } line_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
    clamp_coord = ({1'b0, c} >= (COORD_W+1)'(TILE_SIZE)) ? COORD_W'(TILE_SIZE - 1) : c;
  endfunction

endpackage

// File: rtl/dda_front.sv
// Front end: accepts line transactions, finds the step count and divides
// both deltas by it, one quotient bit per cycle. Depends on dda_pkg.
module dda_front import dda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  in_item_t   item,
  output logic       busy,
  input  q_status_t  q_stat,
  output logic       push,
  output line_desc_t desc
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t          state;
  logic [COORD_W-1:0]    x0, y0, len;
  logic                  xneg, yneg;
  logic [QUOT_W-1:0]     numx, numy;
  logic [COORD_W-1:0]    remx, remy;
  logic [DIV_CNT_W-1:0]  cnt;

  logic [COORD_W-1:0]    cx0, cy0, cx1, cy1, ax, ay, len_next;
  logic [COORD_W:0]      dx, dy, tx, ty, dvx, dvy;
  logic                  gex, gey;

  always_comb begin
    cx0 = clamp_coord(item.start_x);
    cy0 = clamp_coord(item.start_y);
    cx1 = clamp_coord(item.end_x);
    cy1 = clamp_coord(item.end_y);
    dx  = {1'b0, cx1} - {1'b0, cx0};
    dy  = {1'b0, cy1} - {1'b0, cy0};
    ax  = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ay  = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    len_next = (ax >= ay) ? ax : ay;
  end

  always_comb begin
    tx  = {remx, numx[QUOT_W-1]};
    ty  = {remy, numy[QUOT_W-1]};
    gex = tx >= {1'b0, len};
    gey = ty >= {1'b0, len};
    dvx = tx - {1'b0, len};
    dvy = ty - {1'b0, len};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start && len_next != '0) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (cnt == DIV_CNT_W'(QUOT_W - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_stat.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      x0   <= cx0;
      y0   <= cy0;
      len  <= len_next;
      xneg <= dx[COORD_W];
      yneg <= dy[COORD_W];
      numx <= {ax, FRACTION_BITS'(0)};
      numy <= {ay, FRACTION_BITS'(0)};
      remx <= '0;
      remy <= '0;
      cnt  <= '0;
    end else if (state == F_DIV) begin
      numx <= {numx[QUOT_W-2:0], gex};
      numy <= {numy[QUOT_W-2:0], gey};
      remx <= gex ? dvx[COORD_W-1:0] : tx[COORD_W-1:0];
      remy <= gey ? dvy[COORD_W-1:0] : ty[COORD_W-1:0];
      cnt  <= cnt + DIV_CNT_W'(1);
    end
  end

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !q_stat.full;

  always_comb begin
    desc.x0   = x0;
    desc.y0   = y0;
    desc.len  = len;
    desc.xinc = xneg ? (INC_W'(0) - numx[INC_W-1:0]) : numx[INC_W-1:0];
    desc.yinc = yneg ? (INC_W'(0) - numy[INC_W-1:0]) : numy[INC_W-1:0];
  end

endmodule

// File: rtl/dda_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on dda_pkg.
module dda_queue import dda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  line_desc_t wr_desc,
  input  logic       pop,
  output line_desc_t rd_desc,
  output q_status_t  q_stat
);

  line_desc_t          entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  assign rd_desc      = entries[rd_ptr];
  assign q_stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

// File: rtl/dda_back.sv
// Back end: takes line descriptors from the queue and steps the two
// fixed-point accumulators, one pixel per cycle. Depends on dda_pkg.
module dda_back import dda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_stat,
  input  line_desc_t rd_desc,
  output logic       pop,
  output logic       strobe,
  output out_item_t  pixel
);

  logic               active;
  logic [COORD_W-1:0] remain;
  logic [ACC_W-1:0]   xacc, yacc;
  logic [INC_W-1:0]   xinc, yinc;

  assign pop = !active && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      remain <= '0;
    end else if (pop) begin
      active <= 1'b1;
      remain <= rd_desc.len;
    end else if (active) begin
      remain <= remain - COORD_W'(1);
      if (remain == COORD_W'(1)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      xacc <= {1'b0, rd_desc.x0, FRACTION_BITS'(0)};
      yacc <= {1'b0, rd_desc.y0, FRACTION_BITS'(0)};
      xinc <= rd_desc.xinc;
      yinc <= rd_desc.yinc;
    end else if (active) begin
      xacc <= xacc + {{(ACC_W-INC_W){xinc[INC_W-1]}}, xinc};
      yacc <= yacc + {{(ACC_W-INC_W){yinc[INC_W-1]}}, yinc};
    end
  end

  assign strobe = active;

  always_comb begin
    pixel.pixel_x    = xacc[ACC_W-1] ? '0 : xacc[FRACTION_BITS +: COORD_W];
    pixel.pixel_y    = yacc[ACC_W-1] ? '0 : yacc[FRACTION_BITS +: COORD_W];
    pixel.last_pixel = active && (remain == COORD_W'(1));
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_remain_nonzero: assert property (@(posedge clk) disable iff (rst)
    active |-> remain != '0) else $error("active line with zero count");
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && pixel.last_pixel |=> !strobe) else $error("pixel after last");
  a_line_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !pixel.last_pixel |=> strobe) else $error("line cut short");
`endif

endmodule

// File: rtl/dda_line_rasterizer.sv
// DDA line rasterizer: one line transaction in, up to 63 pixel results out.
// From accept to first pixel: restoring divide, queue push, then pop into the back end.
// The one-bit-per-cycle divider and the one-pixel-per-cycle stepper overlap through a
// two-entry descriptor queue.
// Reset: synchronous rst empties the queue and idles both ends; results cannot stall.
// Depends on dda_pkg, dda_front, dda_queue and dda_back.
module dda_line_rasterizer import dda_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      strobe,
  output out_item_t pixel
);

  q_status_t  q_stat;
  logic       push, pop;
  line_desc_t wr_desc, rd_desc;

  dda_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .q_stat (q_stat),
    .push   (push),
    .desc   (wr_desc)
  );

  dda_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_desc (wr_desc),
    .pop     (pop),
    .rd_desc (rd_desc),
    .q_stat  (q_stat)
  );

  dda_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .rd_desc (rd_desc),
    .pop     (pop),
    .strobe  (strobe),
    .pixel   (pixel)
  );

endmodule

// File: verif/tb_dda_line_rasterizer.sv
// Testbench for dda_line_rasterizer: drives line transactions with random gaps and checks
// every pixel against a fixed-point DDA predictor kept inside this file.
// Depends on dda_pkg and the dda_line_rasterizer RTL.
module tb_dda_line_rasterizer;
  import dda_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_LINES = 230;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    in_item_t line;
    int       gap;
    bit       drain;
  } line_job_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item = '0;
  logic      strobe;
  out_item_t pixel;

  line_job_t lines_to_send[$];
  out_item_t pending_pixels[$];

  bit took = 1'b0;
  int idle_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int lines_accepted = 0;
  int zero_lines = 0;
  int pixels_checked = 0;

  dda_line_rasterizer u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .strobe(strobe),
    .pixel (pixel)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic int clip_coord(input logic [COORD_W-1:0] c);
    return (int'(c) >= TILE_SIZE) ? TILE_SIZE - 1 : int'(c);
  endfunction

  function automatic logic [COORD_W-1:0] floor_acc(input longint acc);
    return (acc < 0) ? '0 : COORD_W'(acc >>> FRACTION_BITS);
  endfunction

  task automatic trace_line(input in_item_t ln);
    int        x0, y0, dx, dy, span;
    longint    xstep, ystep, xacc, yacc;
    out_item_t px;
    x0 = clip_coord(ln.start_x);
    y0 = clip_coord(ln.start_y);
    dx = clip_coord(ln.end_x) - x0;
    dy = clip_coord(ln.end_y) - y0;
    span = ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) ? (dx < 0 ? -dx : dx)
                                                        : (dy < 0 ? -dy : dy);
    if (span == 0) begin
      zero_lines++;
      return;
    end
    xstep = (longint'(dx) * (longint'(1) << FRACTION_BITS)) / longint'(span);
    ystep = (longint'(dy) * (longint'(1) << FRACTION_BITS)) / longint'(span);
    xacc = longint'(x0) << FRACTION_BITS;
    yacc = longint'(y0) << FRACTION_BITS;
    for (int i = 0; i < span; i++) begin
      px.pixel_x = floor_acc(xacc);
      px.pixel_y = floor_acc(yacc);
      px.last_pixel = (i == span - 1);
      pending_pixels.push_back(px);
      xacc += xstep;
      yacc += ystep;
    end
  endtask

  task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                          input int gap, input bit drain);
    line_job_t job;
    job.line.start_x = COORD_W'(sx);
    job.line.start_y = COORD_W'(sy);
    job.line.end_x = COORD_W'(ex);
    job.line.end_y = COORD_W'(ey);
    job.gap = gap;
    job.drain = drain;
    lines_to_send.push_back(job);
  endtask

  function automatic int near_coord(input int c);
    int v;
    v = c + int'($urandom_range(0, 8)) - 4;
    return (v < 0) ? 0 : (v > TILE_SIZE - 1) ? TILE_SIZE - 1 : v;
  endfunction

  // monitor: check pixels, then record the accepted line
  always @(posedge clk) begin
    out_item_t exp_px;
    cycles++;
    if (!rst && strobe) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                  pixel.pixel_x, pixel.pixel_y, pixel.last_pixel));
      end else begin
        exp_px = pending_pixels.pop_front();
        pixels_checked++;
        if (pixel.pixel_x !== exp_px.pixel_x)
          report_mismatch($sformatf("pixel_x %0d, want %0d", pixel.pixel_x, exp_px.pixel_x));
        if (pixel.pixel_y !== exp_px.pixel_y)
          report_mismatch($sformatf("pixel_y %0d, want %0d", pixel.pixel_y, exp_px.pixel_y));
        if (pixel.last_pixel !== exp_px.last_pixel)
          report_mismatch($sformatf("last_pixel %0b, want %0b",
                                    pixel.last_pixel, exp_px.last_pixel));
      end
    end
    took <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      lines_accepted++;
      trace_line(item);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("dda_line_rasterizer test failed");
      $finish;
    end
  end

  // driver: hold until accepted, then idle or present the next line
  always @(negedge clk) begin
    line_job_t job;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left--;
    end else if (lines_to_send.size() > 0 &&
                 !(lines_to_send[0].drain && pending_pixels.size() > 0)) begin
      job = lines_to_send.pop_front();
      item <= job.line;
      start <= 1'b1;
      idle_left = job.gap;
    end else begin
      start <= 1'b0;
    end
  end

  initial begin
    int sx, sy, ex, ey, kind, gap;
    bit burst;

    add_line(0, 0, 0, 0, 0, 0);
    add_line(63, 63, 63, 63, 0, 0);
    add_line(0, 0, 63, 63, 0, 0);
    add_line(63, 63, 0, 0, 0, 0);
    add_line(0, 63, 63, 0, 3, 0);
    add_line(63, 0, 0, 63, 0, 1);
    add_line(0, 5, 63, 5, 0, 0);
    add_line(63, 40, 0, 40, 1, 0);
    add_line(7, 0, 7, 63, 0, 0);
    add_line(50, 63, 50, 0, 0, 0);
    add_line(0, 0, 1, 63, 2, 0);
    add_line(0, 0, 63, 1, 0, 0);
    add_line(63, 63, 62, 0, 0, 0);
    add_line(63, 0, 0, 1, 6, 0);
    add_line(10, 10, 11, 10, 0, 0);
    add_line(10, 10, 9, 9, 0, 0);
    add_line(10, 10, 10, 11, 0, 0);
    add_line(0, 0, 63, 20, 0, 0);
    add_line(63, 63, 20, 0, 4, 0);
    add_line(31, 32, 0, 11, 0, 0);
    add_line(5, 60, 62, 3, 0, 1);
    add_line(42, 21, 42, 21, 0, 0);
    add_line(0, 63, 62, 63, 0, 0);

    burst = 1'b0;
    for (int n = 0; n < RANDOM_LINES; n++) begin
      if (n % 20 == 0) burst = $urandom_range(0, 2) == 0;
      kind = $urandom_range(0, 9);
      sx = $urandom_range(0, TILE_SIZE - 1);
      sy = $urandom_range(0, TILE_SIZE - 1);
      ex = $urandom_range(0, TILE_SIZE - 1);
      ey = $urandom_range(0, TILE_SIZE - 1);
      if (kind == 0) begin
        ex = sx;
        ey = sy;
      end else if (kind <= 3) begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end else if (kind == 4) begin
        sx = $urandom_range(0, 1) * (TILE_SIZE - 1);
        ey = $urandom_range(0, 1) * (TILE_SIZE - 1);
      end
      gap = burst ? 0 : $urandom_range(0, 6);
      add_line(sx, sy, ex, ey, gap, n % 45 == 44);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (lines_to_send.size() > 0 || start) @(posedge clk);
    while (pending_pixels.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() > 0)
      report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));

    $display("covered %0d lines (%0d of zero length), %0d pixels checked, %0d mismatches",
             lines_accepted, zero_lines, pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("dda_line_rasterizer test passed");
    end else begin
      $display("dda_line_rasterizer test failed");
    end
    $finish;
  end

endmodule
